// ===== design/bdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bdc_pkg;

    // Field widths of the date words
    localparam int DAY_FIELD_W   = 5;
    localparam int MONTH_FIELD_W = 4;
    localparam int YEAR_W        = 14;
    localparam int WEEKDAY_W     = 3;

    // Day serials reach about 6.13 million for year 16383, so 23 bits hold them
    localparam int DAY_W  = 23;

    // Default width of the business day count
    localparam int COUNT_WIDTH_DEF = 16;

    // Year divided by 100 as a multiply by a rounded-up reciprocal; exact below 43690
    localparam int RECIP_W    = 15;
    localparam int HUND_RECIP = 20972;
    localparam int HUND_SHIFT = 21;
    localparam int HUND_W     = 8;
    localparam int PROD_W     = YEAR_W + RECIP_W;

    // Span divided by 7 as a multiply by a rounded-up reciprocal; exact for any 23-bit span
    localparam int DIV7_RECIP_W = 24;
    localparam int DIV7_RECIP   = 9586981;
    localparam int DIV7_SHIFT   = 26;
    localparam int DIV7_PROD_W  = DAY_W + DIV7_RECIP_W;

    // Shifted year width (year + 400)
    localparam int YY_W = 15;

    localparam int DAYS_PER_YEAR = 365;
    localparam int DAYS_PER_WEEK = 7;
    localparam int CENTURY       = 100;
    localparam int EPOCH_SHIFT   = 400;
    localparam int MONTH_SPLIT   = 3;
    localparam int MONTHS        = 12;

    // Weekday sum width and a bias (a multiple of 7) that keeps it positive
    localparam int WSUM_W  = 16;
    localparam int WD_BIAS = 175;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_QUOT,
        ST_PREP,
        ST_SERIAL,
        ST_DIFF,
        ST_DIV,
        ST_COUNT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_END_BEFORE = 2'd1,
        STATUS_BAD_DATE   = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic quot;
        logic prep;
        logic serial;
        logic diff;
        logic div_step;
        logic count;
    } dp_cmd_t;

    typedef struct packed {
        logic skip;
    } dp_stat_t;

    // Month length, zero for a month outside 1..12
    function automatic logic [DAY_FIELD_W-1:0] month_days(
        input logic [MONTH_FIELD_W-1:0] month,
        input logic                     leap
    );
        logic [DAY_FIELD_W-1:0] len;
        unique case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Month counted from March, 0 for March to 11 for February
    function automatic logic [MONTH_FIELD_W-1:0] month_shift(
        input logic [MONTH_FIELD_W-1:0] month
    );
        logic [MONTH_FIELD_W-1:0] mp;
        if (month >= MONTH_FIELD_W'(MONTH_SPLIT))
            mp = month - MONTH_FIELD_W'(MONTH_SPLIT);
        else
            mp = month + MONTH_FIELD_W'(MONTHS - MONTH_SPLIT);
        return mp;
    endfunction

    // Days before the first of a month in a year that starts in March
    function automatic logic [8:0] cum_days(input logic [MONTH_FIELD_W-1:0] mp);
        logic [8:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Month term of the weekday formula, taken mod 7
    function automatic logic [WEEKDAY_W-1:0] month_wd(input logic [MONTH_FIELD_W-1:0] mp);
        logic [WEEKDAY_W-1:0] w;
        unique case (mp)
            4'd0:    w = 3'd2;
            4'd1:    w = 3'd5;
            4'd2:    w = 3'd0;
            4'd3:    w = 3'd3;
            4'd4:    w = 3'd5;
            4'd5:    w = 3'd1;
            4'd6:    w = 3'd4;
            4'd7:    w = 3'd6;
            4'd8:    w = 3'd2;
            4'd9:    w = 3'd4;
            4'd10:   w = 3'd0;
            4'd11:   w = 3'd3;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

    // Remainder by 7: fold octal digits, since 8 is 1 mod 7
    function automatic logic [WEEKDAY_W-1:0] mod7_16(input logic [WSUM_W-1:0] x);
        logic [5:0] s1;
        logic [3:0] s2;
        logic [3:0] s3;
        s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9])
           + 6'(x[14:12]) + 6'(x[15]);
        s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
        s3 = 4'(s2[2:0]) + 4'(s2[3]);
        if (s3 >= 4'(DAYS_PER_WEEK))
            return 3'(s3 - 4'(DAYS_PER_WEEK));
        return s3[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/bdc_date.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdc_date (
    input  wire logic                                clk,
    input  wire bdc_pkg::dp_cmd_t                    cmd,
    input  wire logic [bdc_pkg::DAY_FIELD_W-1:0]     day,
    input  wire logic [bdc_pkg::MONTH_FIELD_W-1:0]   month,
    input  wire logic [bdc_pkg::YEAR_W-1:0]          year,
    output logic                                     date_ok,
    output logic [bdc_pkg::DAY_W-1:0]                serial,
    output logic [bdc_pkg::WEEKDAY_W-1:0]            weekday
);

    logic [bdc_pkg::DAY_FIELD_W-1:0]   day_reg;
    logic [bdc_pkg::MONTH_FIELD_W-1:0] month_reg;
    logic [bdc_pkg::YEAR_W-1:0]        year_reg;
    logic [bdc_pkg::HUND_W-1:0]        hund_reg;
    logic                              ok_reg;
    logic                              ok_next;
    logic [bdc_pkg::YY_W-1:0]          yy_reg;
    logic [bdc_pkg::YY_W-1:0]          yy_next;
    logic [bdc_pkg::HUND_W-1:0]        yc_reg;
    logic [bdc_pkg::HUND_W-1:0]        yc_next;
    logic [bdc_pkg::MONTH_FIELD_W-1:0] mp_reg;
    logic [bdc_pkg::DAY_W-1:0]         serial_reg;
    logic [bdc_pkg::DAY_W-1:0]         serial_next;
    logic [bdc_pkg::WEEKDAY_W-1:0]     weekday_reg;
    logic [bdc_pkg::WSUM_W-1:0]        wsum;
    logic [bdc_pkg::PROD_W-1:0]        hund_prod;
    logic [bdc_pkg::YEAR_W-1:0]        hund_x100;
    logic [6:0]                        cent_rem;
    logic                              early;
    logic                              leap;
    logic [bdc_pkg::DAY_FIELD_W-1:0]   mlen;

    // Year over 100 by reciprocal multiply
    assign hund_prod = bdc_pkg::PROD_W'(year_reg) * bdc_pkg::PROD_W'(bdc_pkg::HUND_RECIP);

    // Leap rule, range check, shifted year and its century
    always_comb
    begin
        hund_x100 = bdc_pkg::YEAR_W'(hund_reg) * bdc_pkg::YEAR_W'(bdc_pkg::CENTURY);
        cent_rem  = 7'(year_reg - hund_x100);
        leap      = (year_reg[1:0] == 2'b00) && ((cent_rem != 7'd0) || (hund_reg[1:0] == 2'b00));
        early     = month_reg < bdc_pkg::MONTH_FIELD_W'(bdc_pkg::MONTH_SPLIT);
        mlen      = bdc_pkg::month_days(month_reg, leap);
        ok_next   = (mlen != '0) && (day_reg != '0) && (day_reg <= mlen);
        yy_next   = bdc_pkg::YY_W'(year_reg) + bdc_pkg::YY_W'(bdc_pkg::EPOCH_SHIFT)
                  - bdc_pkg::YY_W'(early);
        yc_next   = hund_reg + bdc_pkg::HUND_W'(bdc_pkg::EPOCH_SHIFT / bdc_pkg::CENTURY)
                  - bdc_pkg::HUND_W'(early && (cent_rem == 7'd0));
    end

    // Day serial and weekday sum
    always_comb
    begin
        serial_next = bdc_pkg::DAY_W'(yy_reg) * bdc_pkg::DAY_W'(bdc_pkg::DAYS_PER_YEAR)
                    + bdc_pkg::DAY_W'(yy_reg >> 2) - bdc_pkg::DAY_W'(yc_reg)
                    + bdc_pkg::DAY_W'(yc_reg >> 2) + bdc_pkg::DAY_W'(bdc_pkg::cum_days(mp_reg))
                    + bdc_pkg::DAY_W'(day_reg) - bdc_pkg::DAY_W'(1);
        wsum        = bdc_pkg::WSUM_W'(day_reg) + bdc_pkg::WSUM_W'(yy_reg)
                    + bdc_pkg::WSUM_W'(yy_reg >> 2) + bdc_pkg::WSUM_W'(yc_reg >> 2)
                    + bdc_pkg::WSUM_W'(bdc_pkg::month_wd(mp_reg))
                    + bdc_pkg::WSUM_W'(bdc_pkg::WD_BIAS) - bdc_pkg::WSUM_W'(yc_reg);
    end

    // Capture the date and advance it through the three steps
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            day_reg   <= day;
            month_reg <= month;
            year_reg  <= year;
        end
        if (cmd.quot)
            hund_reg <= hund_prod[bdc_pkg::HUND_SHIFT +: bdc_pkg::HUND_W];
        if (cmd.prep)
        begin
            ok_reg <= ok_next;
            yy_reg <= yy_next;
            yc_reg <= yc_next;
            mp_reg <= bdc_pkg::month_shift(month_reg);
        end
        if (cmd.serial)
        begin
            serial_reg  <= serial_next;
            weekday_reg <= bdc_pkg::mod7_16(wsum);
        end
    end

    assign date_ok = ok_reg;
    assign serial  = serial_reg;
    assign weekday = weekday_reg;

endmodule

`default_nettype wire

// ===== design/bdc_div7.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdc_div7 (
    input  wire logic                          clk,
    input  wire logic                          load,
    input  wire logic                          step,
    input  wire logic [bdc_pkg::DAY_W-1:0]     dividend,
    output logic [bdc_pkg::DAY_W-1:0]          quot,
    output logic [bdc_pkg::WEEKDAY_W-1:0]      rem
);

    logic [bdc_pkg::DAY_W-1:0]       num_reg;
    logic [bdc_pkg::DAY_W-1:0]       quot_reg;
    logic [bdc_pkg::DAY_W-1:0]       quot_next;
    logic [bdc_pkg::DIV7_PROD_W-1:0] prod;

    // Quotient by reciprocal multiply
    assign prod      = bdc_pkg::DIV7_PROD_W'(num_reg)
                     * bdc_pkg::DIV7_PROD_W'(bdc_pkg::DIV7_RECIP);
    assign quot_next = bdc_pkg::DAY_W'(prod[bdc_pkg::DIV7_PROD_W-1:bdc_pkg::DIV7_SHIFT]);

    // Hold the span, then take its quotient in one step
    always_ff @(posedge clk)
    begin
        if (load)
            num_reg <= dividend;
        if (step)
            quot_reg <= quot_next;
    end

    // Remainder from the low bits: span - 7q equals span + q modulo 8
    assign quot = quot_reg;
    assign rem  = bdc_pkg::WEEKDAY_W'(num_reg[bdc_pkg::WEEKDAY_W-1:0]
                                      + quot_reg[bdc_pkg::WEEKDAY_W-1:0]);

endmodule

`default_nettype wire

// ===== design/bdc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdc_datapath #(
    parameter int COUNT_WIDTH = bdc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire bdc_pkg::dp_cmd_t                    cmd,
    output bdc_pkg::dp_stat_t                        stat,
    input  wire logic                                cfg_we,
    input  wire logic [6:0]                          cfg_weekend_mask,
    input  wire logic [bdc_pkg::DAY_FIELD_W-1:0]     start_day,
    input  wire logic [bdc_pkg::MONTH_FIELD_W-1:0]   start_month,
    input  wire logic [bdc_pkg::YEAR_W-1:0]          start_year,
    input  wire logic [bdc_pkg::DAY_FIELD_W-1:0]     end_day,
    input  wire logic [bdc_pkg::MONTH_FIELD_W-1:0]   end_month,
    input  wire logic [bdc_pkg::YEAR_W-1:0]          end_year,
    output logic [COUNT_WIDTH-1:0]                   business_days,
    output logic [bdc_pkg::WEEKDAY_W-1:0]            start_weekday,
    output logic [bdc_pkg::WEEKDAY_W-1:0]            end_weekday,
    output logic [1:0]                               status
);

    localparam int WIDE_W = (COUNT_WIDTH > bdc_pkg::DAY_W) ? COUNT_WIDTH : bdc_pkg::DAY_W;

    logic [6:0]                    mask_reg;
    logic                          s_ok;
    logic                          e_ok;
    logic [bdc_pkg::DAY_W-1:0]     s_serial;
    logic [bdc_pkg::DAY_W-1:0]     e_serial;
    logic [bdc_pkg::WEEKDAY_W-1:0] s_wd;
    logic [bdc_pkg::WEEKDAY_W-1:0] e_wd;
    logic                          bad_date;
    logic                          end_before;
    logic [bdc_pkg::DAY_W-1:0]     span;
    logic [bdc_pkg::DAY_W-1:0]     quot;
    logic [bdc_pkg::WEEKDAY_W-1:0] rem;
    logic [6:0]                    biz;
    logic [2:0]                    biz_total;
    logic [2:0]                    extra;
    logic [bdc_pkg::DAY_W-1:0]     total;
    logic [WIDE_W-1:0]             total_wide;
    logic [WIDE_W-1:0]             cmax_wide;
    logic [COUNT_WIDTH-1:0]        count_reg;
    logic [COUNT_WIDTH-1:0]        count_next;
    logic [bdc_pkg::WEEKDAY_W-1:0] s_wd_reg;
    logic [bdc_pkg::WEEKDAY_W-1:0] e_wd_reg;
    bdc_pkg::status_t              status_reg;
    bdc_pkg::status_t              status_next;

    bdc_date u_start (
        .clk     (clk),
        .cmd     (cmd),
        .day     (start_day),
        .month   (start_month),
        .year    (start_year),
        .date_ok (s_ok),
        .serial  (s_serial),
        .weekday (s_wd)
    );

    bdc_date u_end (
        .clk     (clk),
        .cmd     (cmd),
        .day     (end_day),
        .month   (end_month),
        .year    (end_year),
        .date_ok (e_ok),
        .serial  (e_serial),
        .weekday (e_wd)
    );

    // Span length in days, end date included
    assign span = e_serial - s_serial + bdc_pkg::DAY_W'(1);

    bdc_div7 u_div7 (
        .clk      (clk),
        .load     (cmd.diff),
        .step     (cmd.div_step),
        .dividend (span),
        .quot     (quot),
        .rem      (rem)
    );

    // Classify the request
    always_comb
    begin
        bad_date   = !(s_ok && e_ok);
        end_before = e_serial < s_serial;
        if (bad_date)
            status_next = bdc_pkg::STATUS_BAD_DATE;
        else if (end_before)
            status_next = bdc_pkg::STATUS_END_BEFORE;
        else
            status_next = bdc_pkg::STATUS_OK;
    end

    assign stat.skip = bad_date || end_before;

    // Count: full weeks times business days a week plus those of the part week, saturating
    always_comb
    begin
        logic [3:0] wd_sum;
        extra = '0;
        for (int k = 0; k < bdc_pkg::DAYS_PER_WEEK; k++)
        begin
            wd_sum = 4'(s_wd_reg) + 4'(k);
            if (wd_sum >= 4'(bdc_pkg::DAYS_PER_WEEK))
                wd_sum = wd_sum - 4'(bdc_pkg::DAYS_PER_WEEK);
            biz[k] = !mask_reg[wd_sum[2:0]];
        end
        for (int k = 0; k < bdc_pkg::DAYS_PER_WEEK; k++)
        begin
            if ((3'(k) < rem) && biz[k])
                extra = extra + 3'd1;
        end
        biz_total  = 3'($countones(biz));
        total      = quot * bdc_pkg::DAY_W'(biz_total) + bdc_pkg::DAY_W'(extra);
        total_wide = WIDE_W'(total);
        cmax_wide  = WIDE_W'({COUNT_WIDTH{1'b1}});
        count_next = (total_wide > cmax_wide) ? COUNT_WIDTH'(cmax_wide)
                                              : COUNT_WIDTH'(total_wide);
    end

    // Hold the weekend mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mask_reg <= 7'h60;
        else if (cfg_we)
            mask_reg <= cfg_weekend_mask;
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            status_reg <= status_next;
            s_wd_reg   <= bad_date ? '0 : s_wd;
            e_wd_reg   <= bad_date ? '0 : e_wd;
            count_reg  <= '0;
        end
        else if (cmd.count)
            count_reg <= count_next;
    end

    assign business_days = count_reg;
    assign start_weekday = s_wd_reg;
    assign end_weekday   = e_wd_reg;
    assign status        = status_reg;

endmodule

`default_nettype wire

// ===== design/bdc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bdc_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire bdc_pkg::dp_stat_t   stat,
    output bdc_pkg::dp_cmd_t         cmd,
    output logic                     busy,
    output logic                     done
);

    bdc_pkg::state_t             state_reg;
    bdc_pkg::state_t             state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bdc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequence one word through the datapath
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            bdc_pkg::ST_IDLE:
            begin
                cmd.load = start;
                if (start)
                    state_next = bdc_pkg::ST_QUOT;
            end
            bdc_pkg::ST_QUOT:
            begin
                cmd.quot   = 1'b1;
                state_next = bdc_pkg::ST_PREP;
            end
            bdc_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = bdc_pkg::ST_SERIAL;
            end
            bdc_pkg::ST_SERIAL:
            begin
                cmd.serial = 1'b1;
                state_next = bdc_pkg::ST_DIFF;
            end
            bdc_pkg::ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = stat.skip ? bdc_pkg::ST_DONE : bdc_pkg::ST_DIV;
            end
            bdc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                state_next   = bdc_pkg::ST_COUNT;
            end
            bdc_pkg::ST_COUNT:
            begin
                cmd.count  = 1'b1;
                state_next = bdc_pkg::ST_DONE;
            end
            bdc_pkg::ST_DONE:
            begin
                state_next = bdc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = state_reg != bdc_pkg::ST_IDLE;
    assign done = state_reg == bdc_pkg::ST_DONE;

    a_div_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bdc_pkg::ST_COUNT) |-> ($past(state_reg) == bdc_pkg::ST_DIV))
        else $error("count step entered before the divide step");

endmodule

`default_nettype wire

// ===== design/business_day_counter.sv =====
// Channel   | Handshake                 | Word
// ----------+---------------------------+----------------------------------------------
// request   | start, busy               | start_day/month/year, end_day/month/year
// result    | done (one-cycle strobe)   | business_days, start_weekday, end_weekday,
//           |                           | status
// config    | cfg_valid, cfg_ready      | cfg_weekend_mask
//
// A request is taken when start is high and busy low; done follows the steps quot, prep,
// serial, diff, div and count for a good range, and quot, prep, serial and diff alone for a
// bad date or a reversed range; busy holds off the next request, taken the cycle after done.
// The sequence of range check, day serials, compare, one reciprocal divide-by-7 step and
// the count does not depend on the length of the span.
// Reset clears the sequencer and loads a weekend mask of Friday and Saturday.
// The result strobe cannot be held off; a word stays on the result ports until the next
// request reaches its compare step.
`timescale 1ns / 1ps
`default_nettype none

module business_day_counter #(
    parameter int COUNT_WIDTH = bdc_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [bdc_pkg::DAY_FIELD_W-1:0]     start_day,
    input  wire logic [bdc_pkg::MONTH_FIELD_W-1:0]   start_month,
    input  wire logic [bdc_pkg::YEAR_W-1:0]          start_year,
    input  wire logic [bdc_pkg::DAY_FIELD_W-1:0]     end_day,
    input  wire logic [bdc_pkg::MONTH_FIELD_W-1:0]   end_month,
    input  wire logic [bdc_pkg::YEAR_W-1:0]          end_year,
    output logic                                     done,
    output logic [COUNT_WIDTH-1:0]                   business_days,
    output logic [bdc_pkg::WEEKDAY_W-1:0]            start_weekday,
    output logic [bdc_pkg::WEEKDAY_W-1:0]            end_weekday,
    output logic [1:0]                               status,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [6:0]                          cfg_weekend_mask
);

    bdc_pkg::dp_cmd_t  cmd;
    bdc_pkg::dp_stat_t stat;
    logic              cfg_we;

    // Take mask writes between requests
    assign cfg_ready = !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    bdc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    bdc_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_weekend_mask (cfg_weekend_mask),
        .start_day        (start_day),
        .start_month      (start_month),
        .start_year       (start_year),
        .end_day          (end_day),
        .end_month        (end_month),
        .end_year         (end_year),
        .business_days    (business_days),
        .start_weekday    (start_weekday),
        .end_weekday      (end_weekday),
        .status           (status)
    );

    a_take_request: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_error_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != bdc_pkg::STATUS_OK)) |-> (business_days == '0))
        else $error("non-zero count on an error result");

    a_bad_weekdays: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == bdc_pkg::STATUS_BAD_DATE))
            |-> ((start_weekday == '0) && (end_weekday == '0)))
        else $error("weekdays not cleared on a bad date");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((start_weekday < 3'(bdc_pkg::DAYS_PER_WEEK))
               && (end_weekday < 3'(bdc_pkg::DAYS_PER_WEEK))))
        else $error("weekday out of range");

endmodule

`default_nettype wire
